### rtl/pdma_pkg.sv
// ----------------------------------------------------------------------------
// pdma_pkg
// Shared constants, types and helpers of the paged data memory access unit.
// ----------------------------------------------------------------------------
package pdma_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_PAGES  = 16;
    localparam int ADDR_W     = 64;
    localparam int DATA_W     = 64;
    localparam int SIZE_W     = 2;
    localparam int CFG_W      = 5;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int PAGE_NUM_W = ADDR_W - PAGE_BITS;
    localparam int MEM_BYTES  = PAGE_BYTES * MAX_PAGES;
    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int LANES      = 8;
    localparam int LANE_BITS  = 3;
    localparam int ROW_BITS   = MEM_AW - LANE_BITS;
    localparam int ROWS       = MEM_BYTES / LANES;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic
    {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [SIZE_W-1:0]
    {
        SIZE_BYTE  = 2'd0,
        SIZE_HALF  = 2'd1,
        SIZE_WORD  = 2'd2,
        SIZE_DWORD = 2'd3
    } size_t;

    typedef struct packed
    {
        logic                 fault;
        logic                 write;
        logic [LANE_BITS-1:0] lane;
        logic [ROW_BITS-1:0]  row;
        logic [LANES-1:0]     byte_mask;
    } req_t;

    function automatic logic [LANES-1:0] size_mask(input logic [SIZE_W-1:0] size);
        logic [LANES-1:0] mask;
        begin
            unique case (size)
                SIZE_BYTE:  mask = 8'h01;
                SIZE_HALF:  mask = 8'h03;
                SIZE_WORD:  mask = 8'h0F;
                SIZE_DWORD: mask = 8'hFF;
                default:    mask = 8'h00;
            endcase
            return mask;
        end
    endfunction

endpackage

### rtl/pdma_check.sv
// ----------------------------------------------------------------------------
// pdma_check
// Bounds check and address split of one access into lane and row.
// ----------------------------------------------------------------------------
module pdma_check
(
    input  logic                         operation,
    input  logic [pdma_pkg::SIZE_W-1:0]  access_size,
    input  logic [pdma_pkg::ADDR_W-1:0]  address,
    input  logic [pdma_pkg::CFG_W-1:0]   pages_present,
    output pdma_pkg::req_t               req
);
    import pdma_pkg::*;

    logic [PAGE_NUM_W-1:0] page;
    logic [PAGE_BITS-1:0]  offset;
    logic [LANE_BITS:0]    nbytes;
    logic [PAGE_BITS:0]    end_sum;
    logic                  over_page;
    logic                  over_max;
    logic                  over_present;
    logic [MEM_AW-1:0]     mem_addr;

    always_comb
    begin
        page         = address[ADDR_W-1:PAGE_BITS];
        offset       = address[PAGE_BITS-1:0];
        nbytes       = (LANE_BITS+1)'(1) << access_size;
        end_sum      = {1'b0, offset} + (PAGE_BITS+1)'(nbytes);
        over_page    = end_sum > (PAGE_BITS+1)'(PAGE_BYTES);
        over_max     = page >= PAGE_NUM_W'(MAX_PAGES);
        over_present = page >= PAGE_NUM_W'(pages_present);
        mem_addr     = address[MEM_AW-1:0];

        req.fault     = over_page | over_max | over_present;
        req.write     = (operation == OP_WRITE);
        req.lane      = mem_addr[LANE_BITS-1:0];
        req.row       = mem_addr[MEM_AW-1:LANE_BITS];
        req.byte_mask = size_mask(access_size);
    end

endmodule

### rtl/pdma_lane_ram.sv
// ----------------------------------------------------------------------------
// pdma_lane_ram
// One byte lane of the data memory: single port, registered read data.
// ----------------------------------------------------------------------------
module pdma_lane_ram
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [pdma_pkg::ROW_BITS-1:0] row,
    input  logic [7:0]                    wdata,
    output logic [7:0]                    rdata
);
    import pdma_pkg::*;

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[row] <= wdata;
        end
        rdata_reg <= mem[row];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/paged_data_memory_access_unit.sv
// ----------------------------------------------------------------------------
// paged_data_memory_access_unit
// Paged, byte-addressed little-endian data memory with bounds checking.
// ----------------------------------------------------------------------------
// Takes one item per clock; busy stays low. The result of an item appears on
// the result ports with done once it has passed the registered read port of
// the eight byte-lane RAMs and then one output register; the receiver
// cannot stall and must take done on the cycle it is high. A write is visible
// to a read issued in the very next cycle. pages_present may be written only
// while no item is in flight.
// ----------------------------------------------------------------------------
module paged_data_memory_access_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [pdma_pkg::SIZE_W-1:0]  access_size,
    input  logic [pdma_pkg::ADDR_W-1:0]  address,
    input  logic [pdma_pkg::DATA_W-1:0]  write_data,
    output logic                         done,
    output logic [pdma_pkg::DATA_W-1:0]  read_data,
    output logic                         status,
    output logic                         sticky_error,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pdma_pkg::CFG_W-1:0]   cfg_data
);
    import pdma_pkg::*;

    req_t                 req;
    logic                 accept;
    logic [CFG_W-1:0]     pages_present_reg;
    logic                 error_reg;
    logic                 error_next;

    logic                 s1_valid_reg;
    logic                 s1_fault_reg;
    logic                 s1_write_reg;
    logic                 s1_sticky_reg;
    logic [LANE_BITS-1:0] s1_lane_reg;
    logic [LANES-1:0]     s1_mask_reg;

    logic [7:0]           lane_rdata [LANES];
    logic [DATA_W-1:0]    read_data_next;

    logic                 done_reg;
    logic                 status_reg;
    logic                 sticky_error_reg;
    logic [DATA_W-1:0]    read_data_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    pdma_check u_check
    (
        .operation     (operation),
        .access_size   (access_size),
        .address       (address),
        .pages_present (pages_present_reg),
        .req           (req)
    );

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [LANE_BITS-1:0] idx;
        logic [ROW_BITS-1:0]  row;
        logic                 we;
        logic [DATA_W-1:0]    wshift;

        always_comb
        begin
            idx    = LANE_BITS'(j) - req.lane;
            row    = req.row + ROW_BITS'(LANE_BITS'(j) < req.lane);
            we     = accept & ~req.fault & req.write & req.byte_mask[idx];
            wshift = write_data >> {idx, 3'b000};
        end

        pdma_lane_ram u_ram
        (
            .clk   (clk),
            .we    (we),
            .row   (row),
            .wdata (wshift[7:0]),
            .rdata (lane_rdata[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_present_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pages_present_reg <= cfg_data;
        end
    end

    assign error_next = error_reg | (accept & req.fault);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            error_reg    <= error_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    // hold the item's control alongside the RAM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fault_reg  <= req.fault;
            s1_write_reg  <= req.write;
            s1_lane_reg   <= req.lane;
            s1_mask_reg   <= req.byte_mask;
            s1_sticky_reg <= error_next;
        end
    end

    // rotate lanes back into byte order and drop bytes past the size; writes and faulted items read as zero
    always_comb
    begin
        read_data_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (s1_mask_reg[k] && !s1_write_reg && !s1_fault_reg)
            begin
                read_data_next[8*k +: 8] = lane_rdata[LANE_BITS'(k) + s1_lane_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            read_data_reg    <= read_data_next;
            status_reg       <= s1_fault_reg;
            sticky_error_reg <= s1_sticky_reg;
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign status       = status_reg;
    assign sticky_error = sticky_error_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result not delivered two cycles after start");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (read_data == '0 && sticky_error))
        else $error("faulted item with data or without sticky error");

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("sticky error flag cleared");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_write_reg) |=> (read_data == '0))
        else $error("write returned nonzero read data");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged data memory access unit. Drives loads and
// stores of every size through the command port, mirrors the paged memory,
// the page limit and the sticky error flag in a scoreboard, and compares every
// result field by field in order. Runs directed corner cases first, then
// random traffic under several page limits and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
    import pdma_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MISMATCH_REPORTS = 10;
    localparam int SEGMENTS         = 6;

    typedef struct
    {
        logic [DATA_W-1:0] read_data;
        logic              status;
        logic              sticky_error;
    } mem_outcome_t;

    class paged_mem_scoreboard;
        logic [7:0]       mem_bytes [MEM_BYTES];
        bit               written   [MEM_BYTES];
        bit               error_seen;
        logic [CFG_W-1:0] pages_present;
        mem_outcome_t     awaited [$];
        int               bad_results;

        function new();
            error_seen    = 1'b0;
            pages_present = CFG_RESET;
            bad_results   = 0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        function bit is_fault(logic [ADDR_W-1:0] addr, size_t sz);
            logic [ADDR_W-1:0] page_num;
            int unsigned       offset;
            page_num = addr >> PAGE_BITS;
            offset   = int'(addr[PAGE_BITS-1:0]);
            return page_num >= pages_present || page_num >= MAX_PAGES ||
                   offset + (1 << sz) > PAGE_BYTES;
        endfunction

        function bit is_written(logic [ADDR_W-1:0] addr, size_t sz);
            int base;
            base = int'(addr[MEM_AW-1:0]);
            for (int i = 0; i < (1 << sz); i++)
                if (!written[base + i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_item(op_t op, size_t sz, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] wdata);
            mem_outcome_t outcome;
            int           base;
            outcome.read_data = '0;
            outcome.status    = 1'b0;
            if (is_fault(addr, sz))
            begin
                error_seen     = 1'b1;
                outcome.status = 1'b1;
            end
            else
            begin
                base = int'(addr[MEM_AW-1:0]);
                for (int i = 0; i < (1 << sz); i++)
                begin
                    if (op == OP_WRITE)
                    begin
                        mem_bytes[base + i] = wdata[8*i +: 8];
                        written[base + i]   = 1'b1;
                    end
                    else
                        outcome.read_data[8*i +: 8] = mem_bytes[base + i];
                end
            end
            outcome.sticky_error = error_seen;
            awaited.push_back(outcome);
        endfunction

        function void check_result(logic [DATA_W-1:0] rd, logic st, logic se);
            mem_outcome_t outcome;
            if (awaited.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MISMATCH_REPORTS)
                    $display("unexpected result: read_data=%h status=%b sticky_error=%b",
                             rd, st, se);
                return;
            end
            outcome = awaited.pop_front();
            if (rd !== outcome.read_data || st !== outcome.status ||
                se !== outcome.sticky_error)
            begin
                bad_results++;
                if (bad_results <= MISMATCH_REPORTS)
                    $display("mismatch: expected read_data=%h status=%b sticky_error=%b,",
                             outcome.read_data, outcome.status, outcome.sticky_error,
                             " got read_data=%h status=%b sticky_error=%b",
                             rd, st, se);
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    op_t               operation    = OP_READ;
    size_t             access_size  = SIZE_BYTE;
    logic [ADDR_W-1:0] address      = '0;
    logic [DATA_W-1:0] write_data   = '0;
    logic              cfg_valid    = 1'b0;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] read_data;
    logic              status;
    logic              sticky_error;
    logic              cfg_ready;

    paged_mem_scoreboard sb;
    logic [ADDR_W-1:0]   recent_writes [$];
    int                  stall_cycles = 0;
    int                  seg_pages [SEGMENTS] = '{1, 31, 0, 8, 17, 16};
    int                  seg_items [SEGMENTS] = '{220, 260, 60, 260, 260, 260};

    paged_data_memory_access_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .access_size  (access_size),
        .address      (address),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .status       (status),
        .sticky_error (sticky_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(read_data, status, sticky_error);
    end

    task automatic send_item(op_t op, size_t sz, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] wdata);
        start       <= 1'b1;
        operation   <= op;
        access_size <= sz;
        address     <= addr;
        write_data  <= wdata;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_item(op, sz, addr, wdata);
        if (op == OP_WRITE && !sb.is_fault(addr, sz))
        begin
            recent_writes.push_back(addr);
            if (recent_writes.size() > 64)
                recent_writes.delete(0);
        end
    endtask

    task automatic hold_off(int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pages(logic [CFG_W-1:0] pages);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= pages;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.pages_present = pages;
    endtask

    task automatic random_item(int idle_pct);
        op_t               op;
        size_t             sz;
        logic [ADDR_W-1:0] addr;
        int                kind;
        int                offset;
        int                pick;
        sz   = size_t'($urandom_range(3));
        op   = op_t'($urandom_range(1));
        kind = $urandom_range(99);
        if (kind < 45 || (kind < 85 && recent_writes.size() == 0))
        begin
            op   = OP_WRITE;
            pick = $urandom_range(9);
            if (pick < 6)
                offset = $urandom_range(255);
            else if (pick < 8)
                offset = PAGE_BYTES - 12 + $urandom_range(11);
            else
                offset = $urandom_range(PAGE_BYTES - 1);
            addr = (64'($urandom_range(MAX_PAGES - 1)) << PAGE_BITS) | 64'(offset);
        end
        else if (kind < 85)
        begin
            op   = OP_READ;
            addr = recent_writes[$urandom_range(recent_writes.size() - 1)];
            if ($urandom_range(1))
                addr = addr + 64'($urandom_range(3));
        end
        else
        begin
            case ($urandom_range(2))
                0: addr = {$urandom, $urandom};
                1: addr = (64'($urandom_range(2 * MAX_PAGES, MAX_PAGES)) << PAGE_BITS) |
                          64'($urandom_range(PAGE_BYTES - 1));
                default: addr = (64'($urandom_range(MAX_PAGES - 1)) << PAGE_BITS) |
                                64'(PAGE_BYTES - 8 + $urandom_range(7));
            endcase
        end
        if (op == OP_READ && !sb.is_fault(addr, sz) && !sb.is_written(addr, sz))
            op = OP_WRITE;
        hold_off(idle_pct);
        send_item(op, sz, addr, {$urandom, $urandom});
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_WRITE, SIZE_DWORD, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_WRITE, SIZE_BYTE, 64'd0, 64'h0123_4567_89AB_CDEF);
        send_item(OP_WRITE, SIZE_HALF, 64'd2, 64'hFEDC_BA98_7654_3210);
        send_item(OP_WRITE, SIZE_WORD, 64'd8, 64'hDEAD_BEEF_CAFE_F00D);
        send_item(OP_WRITE, SIZE_DWORD, 64'd16, 64'h0);
        send_item(OP_READ, SIZE_DWORD, 64'd0, 64'h0);
        send_item(OP_READ, SIZE_BYTE, 64'd1, 64'h0);
        send_item(OP_READ, SIZE_HALF, 64'd2, 64'h0);
        send_item(OP_READ, SIZE_WORD, 64'd8, 64'h0);
        send_item(OP_READ, SIZE_DWORD, 64'd16, 64'h0);
        send_item(OP_READ, SIZE_DWORD, 64'd4, 64'h0);
        send_item(OP_WRITE, SIZE_DWORD, 64'(MEM_BYTES - 8), 64'hA5A5_5A5A_C3C3_3C3C);
        send_item(OP_READ, SIZE_DWORD, 64'(MEM_BYTES - 8), 64'h0);
        send_item(OP_WRITE, SIZE_BYTE, 64'(PAGE_BYTES - 1), 64'h0000_0000_0000_0077);
        send_item(OP_READ, SIZE_BYTE, 64'(PAGE_BYTES - 1), 64'h0);
        send_item(OP_WRITE, SIZE_DWORD, 64'(PAGE_BYTES + 3), 64'h1122_3344_5566_7788);
        send_item(OP_READ, SIZE_DWORD, 64'(PAGE_BYTES + 3), 64'h0);
        send_item(OP_READ, SIZE_HALF, 64'(PAGE_BYTES + 9), 64'h0);
        send_item(OP_WRITE, SIZE_DWORD, 64'(PAGE_BYTES - 7), 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_READ, SIZE_WORD, 64'(PAGE_BYTES - 3), 64'h0);
        send_item(OP_READ, SIZE_HALF, 64'(PAGE_BYTES - 1), 64'h0);
        send_item(OP_READ, SIZE_BYTE, 64'(MEM_BYTES), 64'h0);
        send_item(OP_READ, SIZE_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(OP_WRITE, SIZE_DWORD, 64'h8000_0000_0000_0010, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_READ, SIZE_BYTE, 64'(PAGE_BYTES - 1), 64'h0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_pages(CFG_W'(seg_pages[seg]));
            for (int n = 0; n < seg_items[seg]; n++)
                random_item(seg < 2 ? 20 : (seg < 4 ? 81 : 0));
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.bad_results == 0 && sb.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
